/* rtl/paict_pkg.sv */
package paict_pkg;

   localparam int unsigned TABLE_ENTRIES_DEF = 256;

   localparam logic [1:0] KIND_INC = 2'd0;
   localparam logic [1:0] KIND_DEC = 2'd1;
   localparam logic [1:0] KIND_QRY = 2'd2;

   localparam logic [2:0] ST_OK        = 3'd0;
   localparam logic [2:0] ST_ZERO      = 3'd1;
   localparam logic [2:0] ST_DEC_MISS  = 3'd2;
   localparam logic [2:0] ST_FULL      = 3'd3;
   localparam logic [2:0] ST_NOT_FOUND = 3'd4;

   localparam logic signed [31:0] CNT_MAX  = 32'sh7FFF_FFFF;
   localparam logic signed [31:0] CNT_MIN  = 32'sh8000_0000;
   localparam logic signed [31:0] CNT_NONE = -32'sd1;
   localparam logic signed [31:0] CNT_ZERO = 32'sd0;
   localparam logic signed [31:0] CNT_ONE  = 32'sd1;

   typedef struct packed {
      logic               done;
      logic [1:0]         kind;
      logic [31:0]        key;
      logic [2:0]         status;
      logic signed [31:0] count;
   } item_type;

endpackage

/* rtl/per_address_inflight_counter_table.sv */
// Per-address in-flight counter table.
// The req channel takes one word per item: req_tuser carries the kind
// (increment, decrement, query) and req_tdata the IPv4 address used as key.
// The rsp channel returns one word per item: status in the low bits of
// rsp_tdata and the signed count above it.
// Items walk a chain of TABLE_ENTRIES cells, one cell per unstalled cycle; each cell
// holds one table entry and updates it as an item passes. Entries fill from
// the first cell onwards, so the first empty cell an item meets is the free
// slot for an insert and marks a miss for anything else.
// rsp_tvalid rises once the item has left the chain: the first cell loads
// it on the accepting edge, each further cell registers it in turn and the
// output register comes last. Items follow each other through the chain, so
// one item is accepted in every cycle that the output is not stalled.
// Reset empties the table and drops every item in flight.
// While rsp_tvalid is high and rsp_tready low the whole chain holds and
// req_tready is low.
module per_address_inflight_counter_table #(
   parameter int unsigned TABLE_ENTRIES = paict_pkg::TABLE_ENTRIES_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // [31:0] ip_address
   input  logic [1:0]  req_tuser,   // [1:0] kind
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata    // [2:0] status, [34:3] count, [39:35] zero
);

   logic                advance;
   logic                chain_vld [0:TABLE_ENTRIES];
   paict_pkg::item_type chain     [0:TABLE_ENTRIES];
   logic [TABLE_ENTRIES-1:0] entry_vld;

   paict_pkg::item_type head;
   paict_pkg::item_type tail;

   logic               rsp_tvalid_ff;
   logic [2:0]         rsp_status_ff;
   logic signed [31:0] rsp_count_ff;

   assign advance    = !rsp_tvalid_ff || rsp_tready;
   assign req_tready = advance;

   always_comb begin
      head.kind   = req_tuser;
      head.key    = req_tdata;
      head.done   = 1'b0;
      head.status = paict_pkg::ST_OK;
      head.count  = paict_pkg::CNT_ZERO;
      if (req_tdata == 32'd0) begin
         head.done   = 1'b1;
         head.status = paict_pkg::ST_ZERO;
         if (req_tuser == paict_pkg::KIND_INC || req_tuser == paict_pkg::KIND_DEC) begin
            head.count = paict_pkg::CNT_ZERO;
         end else begin
            head.count = paict_pkg::CNT_NONE;
         end
      end
   end

   assign chain_vld[0] = req_tvalid;
   assign chain[0]     = head;

   for (genvar i = 0; i < TABLE_ENTRIES; i++) begin : g_cell
      paict_cell u_cell (
         .clock       (clock),
         .reset       (reset),
         .advance     (advance),
         .item_vld_i  (chain_vld[i]),
         .item_i      (chain[i]),
         .item_vld_o  (chain_vld[i+1]),
         .item_o      (chain[i+1]),
         .entry_vld_o (entry_vld[i])
      );
   end

   // resolve items that ran off the end of a full table
   always_comb begin
      tail = chain[TABLE_ENTRIES];
      if (!tail.done) begin
         case (tail.kind)
            paict_pkg::KIND_INC: begin
               tail.status = paict_pkg::ST_FULL;
               tail.count  = paict_pkg::CNT_ZERO;
            end
            paict_pkg::KIND_DEC: begin
               tail.status = paict_pkg::ST_DEC_MISS;
               tail.count  = paict_pkg::CNT_ZERO;
            end
            default: begin
               tail.status = paict_pkg::ST_NOT_FOUND;
               tail.count  = paict_pkg::CNT_NONE;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_tvalid_ff <= 1'b0;
      end else if (advance) begin
         rsp_tvalid_ff <= chain_vld[TABLE_ENTRIES];
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_status_ff <= tail.status;
         rsp_count_ff  <= tail.count;
      end
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = {5'd0, rsp_count_ff, rsp_status_ff};

   a_valid_prefix: assert property (@(posedge clock) disable iff (reset)
      ((entry_vld & (entry_vld + 1'b1)) == '0))
      else $error("table entries not filled from the first cell");

   a_miss_count: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid_ff && (rsp_status_ff == paict_pkg::ST_FULL ||
                        rsp_status_ff == paict_pkg::ST_DEC_MISS)
      |-> rsp_count_ff == paict_pkg::CNT_ZERO)
      else $error("miss or full result with nonzero count");

   a_not_found_count: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid_ff && rsp_status_ff == paict_pkg::ST_NOT_FOUND
      |-> rsp_count_ff == paict_pkg::CNT_NONE)
      else $error("not-found result without count of minus one");

   a_hold_on_stall: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid_ff && !rsp_tready |=> $stable(entry_vld))
      else $error("table changed while output stalled");

endmodule

/* rtl/paict_cell.sv */
module paict_cell (
   input  logic                clock,
   input  logic                reset,
   input  logic                advance,
   input  logic                item_vld_i,
   input  paict_pkg::item_type item_i,
   output logic                item_vld_o,
   output paict_pkg::item_type item_o,
   output logic                entry_vld_o
);

   logic                item_vld_ff;
   paict_pkg::item_type item_ff;
   paict_pkg::item_type item_in;
   logic                valid_ff;
   logic                valid_in;
   logic [31:0]         key_ff;
   logic [31:0]         key_in;
   logic signed [31:0]  count_ff;
   logic signed [31:0]  count_in;
   logic                hit;

   always_comb begin
      item_in  = item_i;
      valid_in = valid_ff;
      key_in   = key_ff;
      count_in = count_ff;
      hit      = valid_ff && (key_ff == item_i.key);
      if (item_vld_i && !item_i.done) begin
         if (hit) begin
            case (item_i.kind)
               paict_pkg::KIND_INC: begin
                  if (count_ff != paict_pkg::CNT_MAX) begin
                     count_in = count_ff + paict_pkg::CNT_ONE;
                  end
               end
               paict_pkg::KIND_DEC: begin
                  if (count_ff != paict_pkg::CNT_MIN) begin
                     count_in = count_ff - paict_pkg::CNT_ONE;
                  end
               end
               default: begin
                  count_in = count_ff;
               end
            endcase
            item_in.done   = 1'b1;
            item_in.status = paict_pkg::ST_OK;
            item_in.count  = count_in;
         end else if (!valid_ff) begin
            // first free slot: every later slot is free too
            item_in.done = 1'b1;
            case (item_i.kind)
               paict_pkg::KIND_INC: begin
                  valid_in       = 1'b1;
                  key_in         = item_i.key;
                  count_in       = paict_pkg::CNT_ONE;
                  item_in.status = paict_pkg::ST_OK;
                  item_in.count  = paict_pkg::CNT_ONE;
               end
               paict_pkg::KIND_DEC: begin
                  item_in.status = paict_pkg::ST_DEC_MISS;
                  item_in.count  = paict_pkg::CNT_ZERO;
               end
               default: begin
                  item_in.status = paict_pkg::ST_NOT_FOUND;
                  item_in.count  = paict_pkg::CNT_NONE;
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         item_vld_ff <= 1'b0;
         valid_ff    <= 1'b0;
      end else if (advance) begin
         item_vld_ff <= item_vld_i;
         valid_ff    <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         item_ff  <= item_in;
         key_ff   <= key_in;
         count_ff <= count_in;
      end
   end

   assign item_vld_o  = item_vld_ff;
   assign item_o      = item_ff;
   assign entry_vld_o = valid_ff;

endmodule
